FILE: rtl/core/psd_pkg.sv
package psd_pkg;

  // Ring depth (samples averaged for the centroid).
  localparam int Window   = 8;
  localparam int WinBits  = (Window > 1) ? $clog2(Window) : 1;

  localparam int PosW     = 24;
  localparam int DtW      = 16;
  localparam int TimerW   = 25;
  localparam int IntervW  = 24;
  localparam int RadiusW  = 20;
  localparam int CfgDataW = 24;
  localparam int CfgAddrW = 2;

  // Window*p - sum fits SumW+1 bits, its magnitude SumW bits.
  localparam int SumW     = PosW + WinBits;
  localparam int DiffW    = SumW + 1;
  localparam int MagW     = SumW;
  localparam int SqW      = 2 * MagW;
  localparam int DistW    = SqW + 2;

  localparam int InDataW  = 88;
  localparam int OutDataW = 8;

  // Register indexes.
  localparam logic [CfgAddrW-1:0] CfgEnable   = 2'd0;
  localparam logic [CfgAddrW-1:0] CfgInterval = 2'd1;
  localparam logic [CfgAddrW-1:0] CfgRadius   = 2'd2;

  localparam logic [IntervW-1:0] IntervRst = 24'd1000;
  localparam logic [RadiusW-1:0] RadiusRst = 20'd16;

endpackage

FILE: rtl/core/position_stall_detector.sv
// Position stall detector.
// Input stream s_axis_*: one word per position update (time step, x/y/z,
// clear flag in tuser). Output stream m_axis_*: one word per input word
// with the blocked and sample_taken flags.
// Registers are written through cfg_we_i/cfg_addr_i/cfg_wdata_i; the user
// must write them only while idle, and the block itself does not enforce it.
// Flow: a word is taken only in the idle state. A word that is cleared,
// disabled, at or below the sample interval or lands in a not yet full
// window goes straight to the done state, which loads its result into the
// output register once that is free, and the block then returns to idle.
// A sample that completes or lands on a full window runs the centroid test
// through one shared squarer: it sums the ring, squares the scaled radius,
// squares the scaled centroid offset of each stored position one component
// per cycle, drains the squarer and loads the output.
// Reset clears the timer, slot index, full flag and restores the register
// defaults (enable 1, interval 1000, radius 16); ring contents are left as
// they are. A stalled receiver holds the output word; the block still
// accepts and works on the next word, and waits only when its next result
// finds the output register occupied.
module position_stall_detector
  import psd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // delta_time, pos_x, pos_y, pos_z
  input  logic [InDataW-1:0]  s_axis_tdata,
  // clear
  input  logic                s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // blocked, sample_taken, zero fill
  output logic [OutDataW-1:0] m_axis_tdata,
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StSum   = 3'd1;
  localparam logic [2:0] StThr   = 3'd2;
  localparam logic [2:0] StDist  = 3'd3;
  localparam logic [2:0] StDrain = 3'd4;
  localparam logic [2:0] StDone  = 3'd5;

  logic [2:0] state_q, state_d;

  logic               enable_q;
  logic [IntervW-1:0] interval_q;
  logic [RadiusW-1:0] radius_q;

  logic [TimerW-1:0]  elapsed_q;
  logic [WinBits-1:0] slot_q;
  logic               full_q;

  logic [2:0][PosW-1:0]  ring_q [Window];
  logic signed [SumW-1:0] sum_q [3];
  logic [SqW-1:0]        thresh_q;
  logic [SqW-1:0]        prod_q;
  logic                  prod_vld_q;
  logic                  prod_last_q;
  logic [DistW-1:0]      acc_q;
  logic                  fail_q;
  logic                  chk_q;
  logic                  taken_q;

  logic [WinBits-1:0] cnt_q;
  logic [1:0]         comp_q;

  logic                  out_vld_q;
  logic [1:0]            out_flags_q;

  // input fields
  logic [DtW-1:0]        in_dt;
  logic [2:0][PosW-1:0]  in_pos;
  logic                  in_clear;
  logic                  in_acc;

  logic [TimerW:0]       tsum;
  logic [TimerW-1:0]     tsat;
  logic                  hit;
  logic                  do_sample;
  logic [WinBits-1:0]    slot_nxt;
  logic                  wrap;

  logic signed [PosW-1:0]  sel_pos;
  logic signed [DiffW-1:0] diff;
  logic [MagW-1:0]         mag;
  logic [MagW-1:0]         thr_base;
  logic [MagW-1:0]         mul_a;
  logic [SqW-1:0]          sq;
  logic [DistW-1:0]        tot;
  logic                    dist_last;
  logic                    out_free;

  assign in_dt     = s_axis_tdata[DtW-1:0];
  assign in_pos[0] = s_axis_tdata[DtW +: PosW];
  assign in_pos[1] = s_axis_tdata[DtW + PosW +: PosW];
  assign in_pos[2] = s_axis_tdata[DtW + 2*PosW +: PosW];
  assign in_clear  = s_axis_tuser;

  assign s_axis_tready = (state_q == StIdle);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign tsum      = {1'b0, elapsed_q} + (TimerW+1)'(in_dt);
  assign tsat      = tsum[TimerW] ? {TimerW{1'b1}} : tsum[TimerW-1:0];
  assign hit       = tsat > TimerW'(interval_q);
  assign do_sample = in_acc && !in_clear && enable_q && hit;
  assign wrap      = (slot_q == WinBits'(Window - 1));
  assign slot_nxt  = wrap ? '0 : slot_q + 1'b1;

  // shared squarer: scaled radius once, then one centroid offset component a cycle
  assign sel_pos  = ring_q[cnt_q][comp_q];
  assign diff     = DiffW'(sel_pos) * DiffW'(Window) - DiffW'(sum_q[comp_q]);
  assign mag      = diff[DiffW-1] ? MagW'(-diff) : MagW'(diff);
  assign thr_base = MagW'(radius_q) * MagW'(Window);
  assign mul_a    = (state_q == StThr) ? thr_base : mag;
  assign sq       = mul_a * mul_a;

  assign tot       = acc_q + DistW'(prod_q);
  assign dist_last = (cnt_q == WinBits'(Window - 1)) && (comp_q == 2'd2);
  assign out_free  = !out_vld_q || m_axis_tready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_acc) begin
          state_d = (do_sample && (full_q || wrap)) ? StSum : StDone;
        end
      end
      StSum: begin
        if (cnt_q == WinBits'(Window - 1)) state_d = StThr;
      end
      StThr:   state_d = StDist;
      StDist: begin
        if (dist_last) state_d = StDrain;
      end
      StDrain: state_d = StDone;
      StDone: begin
        if (out_free) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      enable_q    <= 1'b1;
      interval_q  <= IntervRst;
      radius_q    <= RadiusRst;
      elapsed_q   <= '0;
      slot_q      <= '0;
      full_q      <= 1'b0;
      cnt_q       <= '0;
      comp_q      <= '0;
      prod_vld_q  <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        case (cfg_addr_i)
          CfgEnable:   enable_q   <= cfg_wdata_i[0];
          CfgInterval: interval_q <= cfg_wdata_i[IntervW-1:0];
          CfgRadius:   radius_q   <= cfg_wdata_i[RadiusW-1:0];
          default: ;
        endcase
      end

      if (in_acc) begin
        if (in_clear) begin
          elapsed_q <= '0;
          slot_q    <= '0;
          full_q    <= 1'b0;
        end else if (enable_q) begin
          if (hit) begin
            elapsed_q <= '0;
            slot_q    <= slot_nxt;
            if (wrap) full_q <= 1'b1;
          end else begin
            elapsed_q <= tsat;
          end
        end
      end

      case (state_q)
        StSum: begin
          cnt_q <= (cnt_q == WinBits'(Window - 1)) ? '0 : cnt_q + 1'b1;
        end
        StDist: begin
          if (comp_q == 2'd2) begin
            comp_q <= '0;
            cnt_q  <= dist_last ? '0 : cnt_q + 1'b1;
          end else begin
            comp_q <= comp_q + 1'b1;
          end
        end
        default: ;
      endcase

      prod_vld_q <= (state_q == StDist);

      if (state_q == StDone && out_free) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_sample) begin
      ring_q[slot_q] <= in_pos;
    end

    if (in_acc) begin
      taken_q <= do_sample;
      chk_q   <= do_sample && (full_q || wrap);
      fail_q  <= 1'b0;
      acc_q   <= '0;
      for (int c = 0; c < 3; c++) sum_q[c] <= '0;
    end

    if (state_q == StSum) begin
      for (int c = 0; c < 3; c++) begin
        sum_q[c] <= sum_q[c] + SumW'($signed(ring_q[cnt_q][c]));
      end
    end

    if (state_q == StThr) thresh_q <= sq;

    if (state_q == StDist) begin
      prod_q      <= sq;
      prod_last_q <= (comp_q == 2'd2);
    end

    // distance of one stored entry is complete with its z term
    if (prod_vld_q) begin
      if (prod_last_q) begin
        if (tot > DistW'(thresh_q)) fail_q <= 1'b1;
        acc_q <= '0;
      end else begin
        acc_q <= tot;
      end
    end

    if (state_q == StDone && out_free) begin
      out_flags_q <= {taken_q, chk_q && !fail_q};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(OutDataW-2){1'b0}}, out_flags_q};

endmodule

FILE: rtl/core/psd_checker.sv
module psd_checker
  import psd_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                s_axis_tuser,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata
);

  // blocked only comes with a logged sample
  a_blocked_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (!m_axis_tdata[0] || m_axis_tdata[1]))
    else $error("blocked without sample_taken");

  // one word in flight: input closes right after an accept
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken while busy");

  // a cleared word never logs a sample
  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser && !m_axis_tvalid)
      |=> ##1 (m_axis_tvalid && m_axis_tdata[1:0] == 2'b00))
    else $error("clear word produced flags");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("output word changed while stalled");

endmodule

bind position_stall_detector psd_checker u_psd_checker (.*);
